>>> sv/gray_and_edge_pixel_filter_macros.svh
// assertion macros for the gray and edge pixel filter
`ifndef GRAY_AND_EDGE_PIXEL_FILTER_MACROS_SVH
`define GRAY_AND_EDGE_PIXEL_FILTER_MACROS_SVH

`ifndef SYNTH
`define GEPF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gepf assertion failed");
`define GEPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gepf assertion failed");
`else
`define GEPF_ASSERT_IMPL(lbl, ante, cons)
`define GEPF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/gepf_pkg.sv
`timescale 1ns / 1ps
package gepf_pkg;

	localparam logic [2:0] MODE_RED   = 3'd0;
	localparam logic [2:0] MODE_GREEN = 3'd1;
	localparam logic [2:0] MODE_BLUE  = 3'd2;
	localparam logic [2:0] MODE_LUMA  = 3'd3;
	localparam logic [2:0] MODE_VEDGE = 3'd4;
	localparam logic [2:0] MODE_HEDGE = 3'd5;

	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_MAX_COLOR  = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

	localparam logic [2:0]  MODE_RESET       = MODE_LUMA;
	localparam logic [7:0]  MAX_COLOR_RESET  = 8'd255;
	localparam logic [10:0] LINE_WIDTH_RESET = 11'd1024;

	localparam logic [23:0] COEF_R = 24'd13933;
	localparam logic [23:0] COEF_G = 24'd46871;
	localparam logic [23:0] COEF_B = 24'd4732;

	localparam int MID_DEPTH = 4;
	localparam int MID_CW    = 3;
	localparam int OUT_DEPTH = 2;
	localparam int OUT_CW    = 2;

	typedef logic [23:0] luma_t;

	typedef struct packed {
		luma_t      luma;
		luma_t      left;
		luma_t      above;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       first_col;
		logic       first_row;
	} mid_entry_t;

endpackage

>>> sv/gepf_ram.sv
`timescale 1ns / 1ps
module gepf_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/gepf_fifo.sv
`timescale 1ns / 1ps
`include "gray_and_edge_pixel_filter_macros.svh"
module gepf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign count = count_q;

	`GEPF_ASSERT_IMPL(a_no_overflow, push, !full)
	`GEPF_ASSERT_IMPL(a_no_underflow, pop, !empty)
	`GEPF_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH))

endmodule

>>> sv/gepf_front.sv
`timescale 1ns / 1ps
`include "gray_and_edge_pixel_filter_macros.svh"
module gepf_front #(
	parameter int MAX_LINE = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic                       frame_start,
	input  logic [10:0]                line_width,
	input  logic [gepf_pkg::MID_CW-1:0] mid_count,
	output logic                       mid_push,
	output gepf_pkg::mid_entry_t       mid_data
);

	import gepf_pkg::*;

	localparam int CW   = $clog2(MAX_LINE);
	localparam int NBW  = $clog2(MAX_LINE + 1);
	localparam int XW   = (NBW > 11) ? NBW : 11;

	logic          accept;
	logic [XW-1:0] line_ext;
	logic [XW-1:0] width_eff;
	logic [XW-1:0] col_start;
	logic [XW-1:0] col_clamp;
	logic          row_first;
	logic          row_last;
	logic [CW-1:0] col_acc;
	logic [MID_CW-1:0] inflight;

	logic [CW-1:0] col_q;
	logic          first_row_q;
	luma_t         left_q;

	logic          v_s1;
	logic [7:0]    red_s1;
	logic [7:0]    green_s1;
	logic [7:0]    blue_s1;
	logic [CW-1:0] col_s1;
	logic          first_row_s1;
	luma_t         luma_c;

	logic          v_s2;
	luma_t         luma_s2;
	luma_t         left_s2;
	logic [7:0]    red_s2;
	logic [7:0]    green_s2;
	logic [7:0]    blue_s2;
	logic          first_col_s2;
	logic          first_row_s2;
	luma_t         above;

	assign inflight = mid_count + MID_CW'(v_s1) + MID_CW'(v_s2);
	assign full     = (inflight >= MID_CW'(MID_DEPTH));
	assign accept   = push && !full;

	always_comb begin
		line_ext = XW'(line_width);
		if (line_ext == '0) begin
			width_eff = XW'(1);
		end else if (line_ext > XW'(MAX_LINE)) begin
			width_eff = XW'(MAX_LINE);
		end else begin
			width_eff = line_ext;
		end
		col_start = frame_start ? '0 : XW'(col_q);
		row_first = frame_start ? 1'b1 : first_row_q;
		if (col_start >= width_eff) begin
			col_clamp = width_eff - XW'(1);
		end else begin
			col_clamp = col_start;
		end
		row_last = ((col_clamp + XW'(1)) >= width_eff);
		col_acc  = col_clamp[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			left_q      <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				if (row_last) begin
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q       <= col_acc + CW'(1);
					first_row_q <= row_first;
				end
			end
			if (v_s1) begin
				left_q <= luma_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1       <= red;
			green_s1     <= green;
			blue_s1      <= blue;
			col_s1       <= col_acc;
			first_row_s1 <= row_first;
		end
		luma_s2      <= luma_c;
		left_s2      <= left_q;
		red_s2       <= red_s1;
		green_s2     <= green_s1;
		blue_s2      <= blue_s1;
		first_col_s2 <= (col_s1 == '0);
		first_row_s2 <= first_row_s1;
	end

	assign luma_c = COEF_R * 24'(red_s1) + COEF_G * 24'(green_s1) + COEF_B * 24'(blue_s1);

	// read-first store: the read sees the row above before this pixel overwrites it
	gepf_ram #(
		.W     ($bits(luma_t)),
		.DEPTH (MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata (luma_c),
		.re    (v_s1),
		.raddr (col_s1),
		.rdata (above)
	);

	assign mid_push = v_s2;

	always_comb begin
		mid_data.luma      = luma_s2;
		mid_data.left      = left_s2;
		mid_data.above     = above;
		mid_data.red       = red_s2;
		mid_data.green     = green_s2;
		mid_data.blue      = blue_s2;
		mid_data.first_col = first_col_s2;
		mid_data.first_row = first_row_s2;
	end

	`GEPF_ASSERT_NEXT(a_accept_enters, accept, v_s1)
	`GEPF_ASSERT_NEXT(a_s1_to_s2, v_s1, v_s2)
	`GEPF_ASSERT_IMPL(a_credit_bound, 1'b1, inflight <= MID_CW'(MID_DEPTH))

endmodule

>>> sv/gepf_back.sv
`timescale 1ns / 1ps
module gepf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           mode,
	input  logic [7:0]           max_color,
	input  logic                 mid_empty,
	input  gepf_pkg::mid_entry_t mid_data,
	output logic                 mid_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           gray
);

	import gepf_pkg::*;

	luma_t       nb;
	luma_t       diff;
	logic [27:0] diff10;
	logic        edge_hit;
	logic [7:0]  edge_lvl;
	logic [7:0]  res;
	logic        out_full;

	function automatic logic [7:0] limit_level(input logic [7:0] v, input logic [7:0] lim);
		return (v > lim) ? 8'd0 : v;
	endfunction

	always_comb begin
		nb       = (mode == MODE_VEDGE) ? mid_data.left : mid_data.above;
		diff     = (mid_data.luma >= nb) ? (mid_data.luma - nb) : (nb - mid_data.luma);
		diff10   = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
		edge_hit = (diff10 >= {4'b0000, max_color, 16'h0000});
		edge_lvl = edge_hit ? max_color : 8'd0;
		case (mode)
			MODE_RED:   res = limit_level(mid_data.red, max_color);
			MODE_GREEN: res = limit_level(mid_data.green, max_color);
			MODE_BLUE:  res = limit_level(mid_data.blue, max_color);
			MODE_LUMA:  res = limit_level(mid_data.luma[23:16], max_color);
			MODE_VEDGE: res = mid_data.first_col ? 8'd0 : edge_lvl;
			MODE_HEDGE: res = mid_data.first_row ? 8'd0 : edge_lvl;
			default:    res = 8'd0;
		endcase
	end

	assign mid_pop = !mid_empty && !out_full;

	gepf_fifo #(
		.W     (8),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_pop),
		.wdata (res),
		.pop   (pop && !empty),
		.rdata (gray),
		.empty (empty),
		.full  (out_full),
		.count ()
	);

endmodule

>>> sv/gray_and_edge_pixel_filter.sv
`timescale 1ns / 1ps
// path: stage 1, stage 2, mid queue, out queue; a pixel shows on gray as empty falls
// throughput: one pixel per cycle unless full, set by front pipeline and line store
// full rises when the decoupling queue plus front stages hold four pixels
// reset: asynchronous, active low; queues empty, column and row restart, registers to
// mode 3, max_color 255, line_width 1024; line store contents are left as they are
module gray_and_edge_pixel_filter #(
	parameter int MAX_LINE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        frame_start,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  gray,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	import gepf_pkg::*;

	logic [2:0]        mode_q;
	logic [7:0]        max_color_q;
	logic [10:0]       line_width_q;

	logic              mid_push;
	logic              mid_pop;
	logic              mid_empty;
	logic [MID_CW-1:0] mid_count;
	mid_entry_t        mid_in;
	mid_entry_t        mid_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RESET;
			max_color_q  <= MAX_COLOR_RESET;
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[2:0];
				REG_MAX_COLOR:  max_color_q  <= cfg_data[7:0];
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gepf_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_start (frame_start),
		.line_width  (line_width_q),
		.mid_count   (mid_count),
		.mid_push    (mid_push),
		.mid_data    (mid_in)
	);

	gepf_fifo #(
		.W     ($bits(mid_entry_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_in),
		.pop   (mid_pop),
		.rdata (mid_out),
		.empty (mid_empty),
		.full  (),
		.count (mid_count)
	);

	gepf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.max_color (max_color_q),
		.mid_empty (mid_empty),
		.mid_data  (mid_out),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.gray      (gray)
	);

endmodule

>>> verif/tb_gray_and_edge_pixel_filter.sv
`timescale 1ns / 1ps
module tb_gray_and_edge_pixel_filter;
	import gepf_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int IDLE_PCT = 19;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  red = 8'd0;
	logic [7:0]  green = 8'd0;
	logic [7:0]  blue = 8'd0;
	logic        frame_start = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  gray;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [10:0] cfg_data = 11'd0;

	pixel_t     pending_pixels[$];
	logic [7:0] expected_gray[$];
	int         errors = 0;
	logic       steady = 1'b0;

	// register copies and filter state
	logic [2:0]  cur_mode = MODE_RESET;
	logic [7:0]  cur_max = MAX_COLOR_RESET;
	logic [10:0] cur_width = LINE_WIDTH_RESET;
	logic [9:0]  col_cnt = 10'd0;
	logic        top_row = 1'b1;
	luma_t       left_luma = '0;
	luma_t       row_store[LINE_DEPTH];

	gray_and_edge_pixel_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.red(red),
		.green(green),
		.blue(blue),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.gray(gray),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #1 clk = ~clk;

	initial begin
		#400000;
		$display("FAIL gray_and_edge_pixel_filter");
		$finish;
	end

	function automatic logic [7:0] clip_level(input logic [7:0] v);
		return (v > cur_max) ? 8'd0 : v;
	endfunction

	function automatic logic [7:0] edge_level(input luma_t a, input luma_t b);
		logic [27:0] diff;
		diff = (a >= b) ? 28'(a - b) : 28'(b - a);
		return (diff * 28'd10 >= {4'd0, cur_max, 16'd0}) ? cur_max : 8'd0;
	endfunction

	task automatic predict_gray(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic fs);
		logic [10:0] width;
		logic [9:0]  col;
		luma_t       luma;
		logic [7:0]  level;
		if (fs) begin
			col_cnt = 10'd0;
			top_row = 1'b1;
		end
		width = cur_width;
		if (width == 11'd0)
			width = 11'd1;
		if (width > 11'(LINE_DEPTH))
			width = 11'(LINE_DEPTH);
		col = ({1'b0, col_cnt} >= width) ? 10'(width - 11'd1) : col_cnt;
		luma = COEF_R * luma_t'(r) + COEF_G * luma_t'(g) + COEF_B * luma_t'(b);
		case (cur_mode)
			MODE_RED: level = clip_level(r);
			MODE_GREEN: level = clip_level(g);
			MODE_BLUE: level = clip_level(b);
			MODE_LUMA: level = clip_level(luma[23:16]);
			MODE_VEDGE: level = (col == 10'd0) ? 8'd0 : edge_level(luma, left_luma);
			MODE_HEDGE: level = top_row ? 8'd0 : edge_level(luma, row_store[col]);
			default: level = 8'd0;
		endcase
		expected_gray.push_back(level);
		left_luma = luma;
		row_store[col] = luma;
		if ({1'b0, col} + 11'd1 >= width) begin
			col_cnt = 10'd0;
			top_row = 1'b0;
		end else begin
			col_cnt = col + 10'd1;
		end
	endtask

	always @(posedge clk) begin : drive_proc
		pixel_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predict_gray(red, green, blue, frame_start);
			if (!push || !full) begin
				if (pending_pixels.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_pixels.pop_front();
					push <= 1'b1;
					red <= nxt.red;
					green <= nxt.green;
					blue <= nxt.blue;
					frame_start <= nxt.frame_start;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		logic [7:0] want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_gray.size() == 0) begin
					$display("%0t: unexpected gray item, expected none, actual %0d",
						$time, gray);
					errors++;
				end else begin
					want = expected_gray.pop_front();
					if (gray !== want) begin
						$display("%0t: gray mismatch, expected %0d, actual %0d",
							$time, want, gray);
						errors++;
					end
				end
			end
			pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic load_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic fs);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.frame_start = fs;
		pending_pixels.push_back(px);
	endtask

	// mix of noise and smooth gray ramps so both edge outcomes show up
	task automatic load_random(input int count, input bit restart);
		pixel_t px;
		int     lvl;
		lvl = int'($urandom_range(0, 255));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				px.red = 8'($urandom);
				px.green = 8'($urandom);
				px.blue = 8'($urandom);
			end else begin
				lvl = lvl + int'($urandom_range(0, 16)) - 8;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 255)
					lvl = 255;
				px.red = 8'(lvl);
				px.green = 8'(lvl) ^ 8'($urandom_range(0, 3));
				px.blue = 8'(lvl);
			end
			px.frame_start = (restart && i == 0) || ($urandom_range(0, 99) < 3);
			pending_pixels.push_back(px);
		end
	endtask

	task automatic settle();
		do @(posedge clk);
		while (pending_pixels.size() != 0 || push || expected_gray.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE: cur_mode = val[2:0];
			REG_MAX_COLOR: cur_max = val[7:0];
			REG_LINE_WIDTH: cur_width = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [2:0] m, input logic [7:0] mx,
		input logic [10:0] w);
		write_reg(REG_MODE, {8'd0, m});
		write_reg(REG_MAX_COLOR, {3'd0, mx});
		write_reg(REG_LINE_WIDTH, w);
	endtask

	// new settings always begin a new frame so no stale row entry is read
	task automatic run_random(input logic [2:0] m, input logic [7:0] mx,
		input logic [10:0] w, input int count);
		settle();
		configure(m, mx, w);
		load_random(count, 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, luminance extremes
		load_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		load_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		load_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
		settle();

		// channel copies with levels around max_color
		configure(MODE_RED, 8'd100, 11'd1024);
		load_pixel(8'd100, 8'd7, 8'd7, 1'b1);
		load_pixel(8'd101, 8'd0, 8'd0, 1'b0);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		settle();
		write_reg(REG_MODE, {8'd0, MODE_GREEN});
		load_pixel(8'd0, 8'd100, 8'd0, 1'b0);
		load_pixel(8'd0, 8'd200, 8'd0, 1'b0);
		settle();
		write_reg(REG_MODE, {8'd0, MODE_BLUE});
		load_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		load_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		settle();
		write_reg(REG_MODE, {8'd0, MODE_LUMA});
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		settle();

		// zero max_color: threshold always met, level zero
		configure(MODE_VEDGE, 8'd0, 11'd4);
		load_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		load_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		load_pixel(8'd9, 8'd9, 8'd9, 1'b0);
		settle();

		// vertical edges, first column of each row
		configure(MODE_VEDGE, 8'd255, 11'd3);
		load_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		load_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		settle();

		// horizontal edges, first row then compare against row above
		configure(MODE_HEDGE, 8'd255, 11'd2);
		load_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		load_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		settle();

		// unused modes, masking of wide data, index past the register list
		write_reg(REG_MODE, {8'd0, MODE_SPARE_6});
		load_pixel(8'd200, 8'd200, 8'd200, 1'b0);
		settle();
		write_reg(REG_MODE, {8'hFF, MODE_SPARE_7});
		write_reg(REG_UNUSED, 11'h7FF);
		load_pixel(8'd255, 8'd0, 8'd255, 1'b0);

		run_random(MODE_VEDGE, 8'd255, 11'd7, 50);
		settle();
		steady = 1'b1;
		run_random(MODE_HEDGE, 8'd255, 11'd5, 60);
		settle();
		steady = 1'b0;
		run_random(MODE_HEDGE, 8'd40, 11'd1, 25);
		run_random(MODE_VEDGE, 8'd0, 11'd0, 15);
		settle();
		write_reg(REG_MODE, {8'd0, MODE_LUMA});
		write_reg(REG_MAX_COLOR, 11'h7C8);
		write_reg(REG_LINE_WIDTH, 11'd16);
		load_random(40, 1'b1);
		run_random(MODE_RED, 8'd128, 11'd9, 20);
		run_random(MODE_GREEN, 8'd128, 11'd9, 20);
		run_random(MODE_BLUE, 8'd128, 11'd9, 20);
		run_random(MODE_HEDGE, 8'd255, 11'd2047, 30);
		run_random(MODE_VEDGE, 8'd255, 11'd2047, 20);
		run_random(MODE_SPARE_7, 8'd255, 11'd6, 10);
		run_random(MODE_HEDGE, 8'd25, 11'd12, 30);
		// sender holds off until the pipe drains, then the row carries on
		settle();
		load_random(30, 1'b0);
		run_random(MODE_VEDGE, 8'd90, 11'd3, 40);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_gray.size() == 0)
			$display("PASS gray_and_edge_pixel_filter");
		else
			$display("FAIL gray_and_edge_pixel_filter");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/gepf_pkg.sv
sv/gepf_ram.sv
sv/gepf_fifo.sv
sv/gepf_front.sv
sv/gepf_back.sv
sv/gray_and_edge_pixel_filter.sv
verif/tb_gray_and_edge_pixel_filter.sv
